// ===== rtl/ufb_pkg.sv =====
// Shared types and constants for the UDP multicast frame builder.
// No dependencies; used by every module under rtl/.
package ufb_pkg;

    // Default sizes
    localparam int FRAME_BYTES_DEF   = 60;
    localparam int PAYLOAD_BYTES_DEF = 11;

    // Byte counter width: a frame is at most 64 bytes
    localparam int CNT_W = 6;

    // Offset of the UDP payload in the frame (Ethernet 14 + IPv4 20 + UDP 8)
    localparam int HDR_BYTES = 42;

    // Fixed header values
    localparam logic [7:0] MAC_MCAST_B0 = 8'h03;
    localparam logic [7:0] ETYPE_HI     = 8'h08;
    localparam logic [7:0] IP_VER_IHL   = 8'h45;
    localparam logic [7:0] IP_TTL       = 8'h01;
    localparam logic [7:0] IP_PROTO_UDP = 8'd17;
    localparam logic [7:0] IP_SRC_B0    = 8'd10;
    localparam logic [7:0] IP_MCAST_B   = 8'd224;
    localparam logic [7:0] UDP_PORT     = 8'd100;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SOURCE_MAC  = 2'd0,
        CFG_FIRST_LINK  = 2'd1,
        CFG_SECOND_LINK = 2'd2,
        CFG_MESSAGE_ID  = 2'd3
    } cfg_index_t;

    // Request payload
    typedef struct packed {
        logic        side_select;
        logic [63:0] sequence_count;
    } request_t;

    // Result payload
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_t;

    // Per-frame context handed from the request stage to the emitter
    typedef struct packed {
        logic [15:0] link;
        logic [7:0]  seq;
        logic [15:0] csum;
    } frame_ctx_t;

endpackage

// ===== rtl/ufb_request.sv =====
// Request stage: registers an accepted request as a frame context
// (link id, sequence byte, IPv4 header checksum). Depends on ufb_pkg.
module ufb_request #(
    parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  ufb_pkg::request_t   request,
    input  logic [15:0]         first_side_link,
    input  logic [15:0]         second_side_link,
    output logic                ctx_valid,
    input  logic                ctx_take,
    output ufb_pkg::frame_ctx_t ctx
);

    // Constant part of the IPv4 header one's-complement sum
    localparam int          IpLen     = 28 + PAYLOAD_BYTES;
    localparam logic [17:0] IpSumBase = 18'(32'h4500 + IpLen + 32'h0111 + 32'h0A00 + 32'hE0E0);

    logic                valid_reg, valid_next;
    ufb_pkg::frame_ctx_t ctx_reg;
    ufb_pkg::frame_ctx_t ctx_new;
    logic                accept;
    logic [15:0]         link;
    logic [10:0]         byte_sum;
    logic [8:0]          fold1;
    logic [7:0]          seq;
    logic [17:0]         ip_sum;
    logic [16:0]         ip_fold1;
    logic [15:0]         ip_fold2;

    // Slot is free when empty or being handed on this cycle
    assign request_stall = valid_reg && !ctx_take;
    assign accept        = request_valid && !request_stall;

    // Sequence byte: count mod 255 via byte folding (256 = 1 mod 255).
    // Zero count folds to 0; a multiple of 255 folds to 255, as required.
    always_comb
    begin
        byte_sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            byte_sum = byte_sum + 11'(request.sequence_count[8*i +: 8]);
        end
        fold1 = 9'(byte_sum[10:8]) + 9'(byte_sum[7:0]);
        seq   = fold1[7:0] + 8'(fold1[8]);
    end

    // Link selection and header checksum
    always_comb
    begin
        link     = request.side_select ? first_side_link : second_side_link;
        ip_sum   = IpSumBase + 18'(link);
        ip_fold1 = 17'(ip_sum[15:0]) + 17'(ip_sum[17:16]);
        ip_fold2 = ip_fold1[15:0] + 16'(ip_fold1[16]);
        ctx_new.link = link;
        ctx_new.seq  = seq;
        ctx_new.csum = ~ip_fold2;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (ctx_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Context payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg <= ctx_new;
        end
    end

    assign ctx_valid = valid_reg;
    assign ctx       = ctx_reg;

endmodule

// ===== rtl/ufb_emitter.sv =====
// Frame emitter: byte counter, frame byte selection and output register.
// Depends on ufb_pkg; fed by ufb_request.
module ufb_emitter #(
    parameter int FRAME_BYTES   = ufb_pkg::FRAME_BYTES_DEF,
    parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ctx_valid,
    output logic                ctx_take,
    input  ufb_pkg::frame_ctx_t ctx,
    input  logic [47:0]         source_mac,
    input  logic [7:0]          message_id,
    output logic                frame_valid,
    input  logic                frame_stall,
    output ufb_pkg::frame_t     frame
);

    localparam int                   W       = ufb_pkg::CNT_W;
    localparam logic [W-1:0]         LastIdx = W'(FRAME_BYTES - 1);
    localparam logic [15:0]          UdpLen  = 16'(8 + PAYLOAD_BYTES);
    localparam logic [15:0]          IpLen   = 16'(28 + PAYLOAD_BYTES);
    localparam logic [W-1:0]         PlMsg   = W'(ufb_pkg::HDR_BYTES);
    localparam logic [W-1:0]         PlLen   = W'(ufb_pkg::HDR_BYTES + 2);
    localparam logic [W-1:0]         PlSeq   = W'(ufb_pkg::HDR_BYTES + PAYLOAD_BYTES - 1);

    logic                busy_reg, busy_next;
    logic [W-1:0]        cnt_reg, cnt_next;
    ufb_pkg::frame_ctx_t ctx_reg;
    logic                out_valid_reg, out_valid_next;
    ufb_pkg::frame_t     out_reg, out_next;
    logic                advance;
    logic                is_last;
    logic [7:0]          byte_val;

    // Output register moves when empty or taken
    assign advance  = !out_valid_reg || !frame_stall;
    assign is_last  = (cnt_reg == LastIdx);
    assign ctx_take = advance && ctx_valid && (!busy_reg || is_last);

    // Frame byte at the current offset
    always_comb
    begin
        byte_val = 8'h00;
        case (cnt_reg)
            W'(0):  byte_val = ufb_pkg::MAC_MCAST_B0;
            W'(4):  byte_val = ctx_reg.link[15:8];
            W'(5):  byte_val = ctx_reg.link[7:0];
            W'(6):  byte_val = source_mac[47:40];
            W'(7):  byte_val = source_mac[39:32];
            W'(8):  byte_val = source_mac[31:24];
            W'(9):  byte_val = source_mac[23:16];
            W'(10): byte_val = source_mac[15:8];
            W'(11): byte_val = source_mac[7:0];
            W'(12): byte_val = ufb_pkg::ETYPE_HI;
            W'(14): byte_val = ufb_pkg::IP_VER_IHL;
            W'(16): byte_val = IpLen[15:8];
            W'(17): byte_val = IpLen[7:0];
            W'(22): byte_val = ufb_pkg::IP_TTL;
            W'(23): byte_val = ufb_pkg::IP_PROTO_UDP;
            W'(24): byte_val = ctx_reg.csum[15:8];
            W'(25): byte_val = ctx_reg.csum[7:0];
            W'(26): byte_val = ufb_pkg::IP_SRC_B0;
            W'(30): byte_val = ufb_pkg::IP_MCAST_B;
            W'(31): byte_val = ufb_pkg::IP_MCAST_B;
            W'(32): byte_val = ctx_reg.link[15:8];
            W'(33): byte_val = ctx_reg.link[7:0];
            W'(35): byte_val = ufb_pkg::UDP_PORT;
            W'(37): byte_val = ufb_pkg::UDP_PORT;
            W'(38): byte_val = UdpLen[15:8];
            W'(39): byte_val = UdpLen[7:0];
            default: byte_val = 8'h00;
        endcase
        // Payload: message id, zero, length, ..., sequence byte last
        if (cnt_reg == PlMsg)
        begin
            byte_val = message_id;
        end
        else if (cnt_reg == PlLen)
        begin
            byte_val = 8'(PAYLOAD_BYTES);
        end
        else if (cnt_reg == PlSeq)
        begin
            byte_val = ctx_reg.seq;
        end
    end

    // Sequencer and output register next state
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next      = busy_reg;
            out_next.frame_byte = byte_val;
            out_next.last_byte  = is_last;
            if (ctx_take)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
            end
            else if (busy_reg)
            begin
                if (is_last)
                begin
                    busy_next = 1'b0;
                end
                cnt_next = cnt_reg + W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (ctx_take)
        begin
            ctx_reg <= ctx;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

`ifndef SYNTHESIS
    // A new frame starts at offset zero
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_take |=> busy_reg && (cnt_reg == '0))
        else $error("frame did not start at offset zero");

    // Counter steps by one per emitted byte inside a frame
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && advance && !is_last |=> cnt_reg == $past(cnt_reg) + W'(1))
        else $error("byte counter skipped");

    // Counter never passes the last offset
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= LastIdx)
        else $error("byte counter beyond frame end");

    // Emitter goes idle after the last byte when nothing is waiting
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && advance && is_last && !ctx_valid |=> !busy_reg)
        else $error("emitter stayed busy after last byte");

    // Flagged last byte is emitted only from the final offset
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && busy_reg |=> out_reg.last_byte == ($past(cnt_reg) == LastIdx))
        else $error("last_byte flag misplaced");
`endif

endmodule

// ===== rtl/udp_multicast_frame_builder.sv =====
// Top level of the UDP multicast frame builder: configuration registers,
// request stage and frame emitter. Depends on ufb_pkg, ufb_request, ufb_emitter.
//
//  channel   direction  handshake                  payload
//  request   in         request_valid/request_stall  ufb_pkg::request_t
//  frame     out        frame_valid/frame_stall      ufb_pkg::frame_t
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Each request yields FRAME_BYTES transfers on frame, one byte per cycle,
// set by the byte counter of the emitter. One request waits in the request
// register while a frame streams, so frames follow with no gap.
// A request passes the request, emitter context and output registers.
// A stall on frame holds the output register and the counter in place.
// Reset clears the configuration registers to zero and empties both stages.
module udp_multicast_frame_builder #(
    parameter int FRAME_BYTES   = ufb_pkg::FRAME_BYTES_DEF,
    parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_stall,
    input  ufb_pkg::request_t request,
    output logic              frame_valid,
    input  logic              frame_stall,
    output ufb_pkg::frame_t   frame,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [47:0]       cfg_data
);

    logic [47:0]         source_mac_reg;
    logic [15:0]         first_link_reg;
    logic [15:0]         second_link_reg;
    logic [7:0]          message_id_reg;
    logic                cfg_write;
    logic                ctx_valid;
    logic                ctx_take;
    ufb_pkg::frame_ctx_t ctx;

    // Configuration writes complete in the same cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg  <= '0;
            first_link_reg  <= '0;
            second_link_reg <= '0;
            message_id_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (ufb_pkg::cfg_index_t'(cfg_index))
                ufb_pkg::CFG_SOURCE_MAC:  source_mac_reg  <= cfg_data;
                ufb_pkg::CFG_FIRST_LINK:  first_link_reg  <= cfg_data[15:0];
                ufb_pkg::CFG_SECOND_LINK: second_link_reg <= cfg_data[15:0];
                ufb_pkg::CFG_MESSAGE_ID:  message_id_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Request register with sequence byte and checksum
    ufb_request #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_request (
        .clk              (clk),
        .rst_n            (rst_n),
        .request_valid    (request_valid),
        .request_stall    (request_stall),
        .request          (request),
        .first_side_link  (first_link_reg),
        .second_side_link (second_link_reg),
        .ctx_valid        (ctx_valid),
        .ctx_take         (ctx_take),
        .ctx              (ctx)
    );

    // Byte sequencer and output register
    ufb_emitter #(
        .FRAME_BYTES   (FRAME_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctx_valid   (ctx_valid),
        .ctx_take    (ctx_take),
        .ctx         (ctx),
        .source_mac  (source_mac_reg),
        .message_id  (message_id_reg),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

endmodule
